// ----- src/vbtm_pkg.sv -----
package vbtm_pkg;

  localparam int INSTRUMENTS   = 16;
  localparam int INST_W        = $clog2(INSTRUMENTS);
  localparam int WINDOW_MAX    = 64;
  localparam int HEAD_W        = $clog2(WINDOW_MAX);
  localparam int FRACTION_BITS = 16;
  localparam int FRAC_W        = FRACTION_BITS + 1;
  localparam int SUM_W         = 33;
  localparam int TOTAL_W       = HEAD_W + FRAC_W;
  localparam int RING_DEPTH    = INSTRUMENTS * WINDOW_MAX;
  localparam int RING_AW       = INST_W + HEAD_W;
  localparam int WIN_W         = 7;
  localparam int PADDR_W       = 5;
  localparam int DIV_STEPS     = FRAC_W;
  localparam int DIV_CNT_W     = $clog2(DIV_STEPS + 1);

  // Register map, word index.
  typedef enum logic [2:0] {
    REG_ENABLED   = 3'd0,
    REG_BUCKET    = 3'd1,
    REG_WINDOW    = 3'd2,
    REG_THRESHOLD = 3'd3,
    REG_COOLDOWN  = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [3:0]  instrument;
    logic [31:0] price;
    logic [31:0] volume;
    logic [31:0] now_seconds;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  instrument_out;
    logic        accepted;
    logic        side_buy;
    logic        bucket_closed;
    logic        metric_valid;
    logic [16:0] metric;
    logic        alert;
  } out_item_t;

  // Classified trade as it travels from front to back.
  typedef struct packed {
    in_item_t item;
    logic     reject;
  } trade_t;

  typedef struct packed {
    logic              enabled;
    logic [31:0]       bucket_volume;
    logic [WIN_W-1:0]  win;
    logic [HEAD_W-1:0] cap;
    logic [16:0]       threshold;
    logic [31:0]       cooldown;
    logic              clear;
  } cfg_t;

endpackage

// ----- src/vbtm_ram.sv -----
module vbtm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- src/vbtm_front.sv -----
module vbtm_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              enabled,
  input  logic              push,
  output logic              full,
  input  vbtm_pkg::in_item_t in_data,
  output logic              q_valid,
  output vbtm_pkg::trade_t  q_head,
  input  logic              q_pop
);
  import vbtm_pkg::*;

  trade_t     slot_r [2];
  logic       wptr_r, wptr_nxt;
  logic       rptr_r, rptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       wr;
  trade_t     cls;

  // Classify: zero volume or an unknown instrument is reported but not counted.
  always_comb begin
    cls.item   = in_data;
    cls.reject = (in_data.volume == 32'd0) ||
                 ({1'b0, in_data.instrument} >= (INST_W + 1)'(INSTRUMENTS));
  end

  assign full    = (cnt_r == 2'd2);
  assign wr      = push && !full && enabled;
  assign q_valid = (cnt_r != 2'd0);
  assign q_head  = slot_r[rptr_r];

  // Two-entry queue pointers.
  always_comb begin
    wptr_nxt = wptr_r ^ wr;
    rptr_nxt = rptr_r ^ (q_pop && q_valid);
    cnt_nxt  = cnt_r + {1'b0, wr} - {1'b0, q_pop && q_valid};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (wr) begin
      slot_r[wptr_r] <= cls;
    end
  end

endmodule

// ----- src/vbtm_div.sv -----
module vbtm_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [32:0] hi,
  input  logic [15:0] lo,
  input  logic [32:0] divisor,
  output logic        done,
  output logic [16:0] quot
);
  import vbtm_pkg::*;

  logic [33:0]          rem_r, rem_nxt;
  logic [15:0]          lo_r, lo_nxt;
  logic [32:0]          div_r;
  logic [16:0]          q_r, q_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic                 qbit;
  logic [33:0]          rem_sub;

  // One quotient bit per cycle, most significant first (restoring).
  always_comb begin
    qbit     = (rem_r >= {1'b0, div_r});
    rem_sub  = qbit ? (rem_r - {1'b0, div_r}) : rem_r;
    rem_nxt  = {rem_sub[32:0], lo_r[15]};
    lo_nxt   = {lo_r[14:0], 1'b0};
    q_nxt    = {q_r[15:0], qbit};
    cnt_nxt  = cnt_r - DIV_CNT_W'(1);
    busy_nxt = busy_r && (cnt_r != DIV_CNT_W'(1));
    done_nxt = busy_r && (cnt_r == DIV_CNT_W'(1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= DIV_CNT_W'(DIV_STEPS);
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      if (busy_r) begin
        cnt_r <= cnt_nxt;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= {1'b0, hi};
      lo_r  <= lo;
      div_r <= divisor;
      q_r   <= '0;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      lo_r  <= lo_nxt;
      q_r   <= q_nxt;
    end
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

// ----- src/vbtm_back.sv -----
module vbtm_back (
  input  logic                clk,
  input  logic                rst_n,
  input  vbtm_pkg::cfg_t      cfg,
  input  logic                q_valid,
  input  vbtm_pkg::trade_t    q_head,
  output logic                q_pop,
  output logic                empty,
  input  logic                pop,
  output vbtm_pkg::out_item_t out_data
);
  import vbtm_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_LOAD  = 8'b0000_0010,
    S_CHECK = 8'b0000_0100,
    S_DIV1  = 8'b0000_1000,
    S_UPD   = 8'b0001_0000,
    S_DIV2  = 8'b0010_0000,
    S_ALERT = 8'b0100_0000,
    S_EMIT  = 8'b1000_0000
  } state_t;

  state_t state_r;

  // Per-instrument state.
  logic [31:0]        prior_price_r [INSTRUMENTS];
  logic               price_seen_r  [INSTRUMENTS];
  logic               prior_side_r  [INSTRUMENTS];
  logic [SUM_W-1:0]   buy_sum_r     [INSTRUMENTS];
  logic [SUM_W-1:0]   tot_sum_r     [INSTRUMENTS];
  logic [FRAC_W-1:0]  newest_r      [INSTRUMENTS];
  logic [WIN_W-1:0]   count_r       [INSTRUMENTS];
  logic [HEAD_W-1:0]  head_r        [INSTRUMENTS];
  logic [TOTAL_W-1:0] dtotal_r      [INSTRUMENTS];
  logic [31:0]        last_alert_r  [INSTRUMENTS];
  logic               alert_seen_r  [INSTRUMENTS];

  // Current trade and its result.
  trade_t             cur_r;
  logic               buy_r, closed_r, valid_r, alert_r;
  logic [16:0]        metric_r;
  logic [FRAC_W-1:0]  frac_r;
  logic               out_valid_r;
  out_item_t          out_r;

  logic [INST_W-1:0]  idx;
  logic               buy;
  logic [FRAC_W-1:0]  diff;
  logic [TOTAL_W:0]   total_new;
  logic [WIN_W-1:0]   count_new;
  logic [HEAD_W-1:0]  head_inc;
  logic               cool_ok;
  logic               div_start;
  logic [32:0]        div_hi, div_div;
  logic [15:0]        div_lo;
  logic               div_done;
  logic [16:0]        div_q;
  logic               ring_we, ring_re;
  logic [FRAC_W-1:0]  ring_q;
  logic               slot_free;

  assign idx = cur_r.item.instrument;

  // Tick rule with carry-over of the prior side.
  always_comb begin
    if (price_seen_r[idx] && cur_r.item.price > prior_price_r[idx]) begin
      buy = 1'b1;
    end else if (price_seen_r[idx] && cur_r.item.price < prior_price_r[idx]) begin
      buy = 1'b0;
    end else begin
      buy = prior_side_r[idx];
    end
  end

  // Window bookkeeping for a closed bucket.
  always_comb begin
    diff      = (frac_r > newest_r[idx]) ? (frac_r - newest_r[idx])
                                         : (newest_r[idx] - frac_r);
    total_new = {1'b0, dtotal_r[idx]} + {(TOTAL_W + 1 - FRAC_W)'(0), diff};
    count_new = count_r[idx];
    if (count_r[idx] >= cfg.win) begin
      total_new = total_new - {(TOTAL_W + 1 - FRAC_W)'(0), ring_q};
    end else begin
      count_new = count_r[idx] + WIN_W'(1);
    end
    head_inc  = (head_r[idx] + HEAD_W'(1) == cfg.cap) ? '0 : head_r[idx] + HEAD_W'(1);
  end

  // Cooldown check; an earlier time than the last alert does not pass.
  assign cool_ok = !alert_seen_r[idx] ||
                   (cur_r.item.now_seconds >= last_alert_r[idx] &&
                    cur_r.item.now_seconds - last_alert_r[idx] >= cfg.cooldown);

  assign slot_free = !out_valid_r || pop;
  assign q_pop     = (state_r == S_IDLE) && q_valid;
  assign ring_re   = (state_r == S_LOAD);
  assign ring_we   = (state_r == S_UPD) && (count_r[idx] != '0);

  // Divider operands: buy fraction first, window mean second.
  always_comb begin
    div_start = 1'b0;
    div_hi    = buy_sum_r[idx];
    div_lo    = '0;
    div_div   = tot_sum_r[idx];
    if (state_r == S_CHECK) begin
      div_start = ({1'b0, cfg.bucket_volume} <= tot_sum_r[idx]);
    end else if (state_r == S_UPD) begin
      div_start = (count_r[idx] == '0) ? (WIN_W'(1) >= cfg.win) : (count_new >= cfg.win);
      div_hi    = {26'd0, total_new[TOTAL_W-1:16]};
      div_lo    = total_new[15:0];
      div_div   = {27'd0, cfg.cap};
    end
  end

  vbtm_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .hi      (div_hi),
    .lo      (div_lo),
    .divisor (div_div),
    .done    (div_done),
    .quot    (div_q)
  );

  vbtm_ram #(.WIDTH(FRAC_W), .DEPTH(RING_DEPTH)) u_ring (
    .clk   (clk),
    .we    (ring_we),
    .waddr ({idx, head_r[idx]}),
    .wdata (diff),
    .re    (ring_re),
    .raddr ({idx, head_r[idx]}),
    .rdata (ring_q)
  );

  // Sequencer and per-instrument state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      for (int i = 0; i < INSTRUMENTS; i++) begin
        prior_price_r[i] <= '0;
        price_seen_r[i]  <= 1'b0;
        prior_side_r[i]  <= 1'b1;
        buy_sum_r[i]     <= '0;
        tot_sum_r[i]     <= '0;
        newest_r[i]      <= '0;
        count_r[i]       <= '0;
        head_r[i]        <= '0;
        dtotal_r[i]      <= '0;
        last_alert_r[i]  <= '0;
        alert_seen_r[i]  <= 1'b0;
      end
    end else begin
      // A popped result frees the slot unless a new one is posted now.
      if (pop && out_valid_r && state_r != S_EMIT) begin
        out_valid_r <= 1'b0;
      end
      if (cfg.clear) begin
        for (int i = 0; i < INSTRUMENTS; i++) begin
          buy_sum_r[i] <= '0;
          tot_sum_r[i] <= '0;
          newest_r[i]  <= '0;
          count_r[i]   <= '0;
          head_r[i]    <= '0;
          dtotal_r[i]  <= '0;
        end
      end
      case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            cur_r    <= q_head;
            closed_r <= 1'b0;
            valid_r  <= 1'b0;
            alert_r  <= 1'b0;
            metric_r <= '0;
            buy_r    <= 1'b0;
            state_r  <= S_LOAD;
          end
        end
        S_LOAD: begin
          if (cur_r.reject) begin
            state_r <= S_EMIT;
          end else begin
            buy_r               <= buy;
            prior_price_r[idx]  <= cur_r.item.price;
            price_seen_r[idx]   <= 1'b1;
            prior_side_r[idx]   <= buy;
            tot_sum_r[idx]      <= tot_sum_r[idx] + {1'b0, cur_r.item.volume};
            if (buy) begin
              buy_sum_r[idx] <= buy_sum_r[idx] + {1'b0, cur_r.item.volume};
            end
            state_r <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (div_start) begin
            closed_r       <= 1'b1;
            buy_sum_r[idx] <= '0;
            tot_sum_r[idx] <= '0;
            state_r        <= S_DIV1;
          end else begin
            state_r <= S_EMIT;
          end
        end
        S_DIV1: begin
          if (div_done) begin
            frac_r  <= div_q;
            state_r <= S_UPD;
          end
        end
        S_UPD: begin
          newest_r[idx] <= frac_r;
          if (count_r[idx] == '0) begin
            count_r[idx] <= WIN_W'(1);
          end else begin
            count_r[idx]  <= count_new;
            dtotal_r[idx] <= total_new[TOTAL_W-1:0];
            head_r[idx]   <= head_inc;
          end
          state_r <= div_start ? S_DIV2 : S_EMIT;
        end
        S_DIV2: begin
          if (div_done) begin
            metric_r <= div_q;
            valid_r  <= 1'b1;
            state_r  <= S_ALERT;
          end
        end
        S_ALERT: begin
          if (metric_r >= cfg.threshold && cool_ok) begin
            alert_r           <= 1'b1;
            alert_seen_r[idx] <= 1'b1;
            last_alert_r[idx] <= cur_r.item.now_seconds;
          end
          state_r <= S_EMIT;
        end
        S_EMIT: begin
          if (slot_free) begin
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (state_r == S_EMIT && slot_free) begin
      out_r.instrument_out <= cur_r.item.instrument;
      out_r.accepted       <= !cur_r.reject;
      out_r.side_buy       <= buy_r;
      out_r.bucket_closed  <= closed_r;
      out_r.metric_valid   <= valid_r;
      out_r.metric         <= metric_r;
      out_r.alert          <= alert_r;
    end
  end

  assign empty    = !out_valid_r;
  assign out_data = out_r;

  a_div_start_place: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> (state_r == S_CHECK || state_r == S_UPD))
    else $error("divider started outside a bucket close");

  a_alert_level: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT && alert_r) |-> (valid_r && metric_r >= cfg.threshold))
    else $error("alert without a metric at threshold");

  a_head_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_UPD) |-> (head_r[idx] < cfg.cap))
    else $error("ring head beyond window");

  a_emit_once: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT && slot_free) |=> (out_valid_r && state_r == S_IDLE))
    else $error("result not posted");

endmodule

// ----- src/volume_bucket_toxicity_monitor_top.sv -----
// Channel   Handshake                 Payload
// input     push / full               in_data  (vbtm_pkg::in_item_t)
// result    empty / pop               out_data (vbtm_pkg::out_item_t)
// config    psel/penable/pwrite/pready paddr, pwdata, prdata
//
// A trade that closes no bucket skips the divider, and a zero volume skips
// the bucket check; a closing trade uses the shared divider for the buy
// fraction and, when the window is full, again for the window mean.
// Each beat passes through the queue first.
// Reset is synchronous and clears all per-instrument state at once.
// A two-beat queue takes trades while the back end works or the result waits.
module volume_bucket_toxicity_monitor_top (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  output logic                         full,
  input  vbtm_pkg::in_item_t           in_data,
  output logic                         empty,
  input  logic                         pop,
  output vbtm_pkg::out_item_t          out_data,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [vbtm_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import vbtm_pkg::*;

  logic        enabled_r;
  logic [31:0] bucket_r;
  logic [6:0]  window_r;
  logic [16:0] thresh_r;
  logic [31:0] cool_r;
  logic        clear_r;
  logic        wr;
  reg_idx_t    ridx;
  logic [WIN_W-1:0] win;
  cfg_t        cfg;
  logic        q_valid, q_pop;
  trade_t      q_head;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign ridx   = reg_idx_t'(paddr[4:2]);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enabled_r <= 1'b0;
      bucket_r  <= 32'd10000;
      window_r  <= 7'd50;
      thresh_r  <= 17'd52429;
      cool_r    <= 32'd300;
      clear_r   <= 1'b0;
    end else begin
      clear_r <= wr && (ridx == REG_BUCKET || ridx == REG_WINDOW);
      if (wr) begin
        case (ridx)
          REG_ENABLED:   enabled_r <= pwdata[0];
          REG_BUCKET:    bucket_r  <= pwdata;
          REG_WINDOW:    window_r  <= pwdata[6:0];
          REG_THRESHOLD: thresh_r  <= pwdata[16:0];
          REG_COOLDOWN:  cool_r    <= pwdata;
          default: ;
        endcase
      end
    end
  end

  // Register readback.
  always_comb begin
    case (ridx)
      REG_ENABLED:   prdata = {31'd0, enabled_r};
      REG_BUCKET:    prdata = bucket_r;
      REG_WINDOW:    prdata = {25'd0, window_r};
      REG_THRESHOLD: prdata = {15'd0, thresh_r};
      REG_COOLDOWN:  prdata = cool_r;
      default:       prdata = 32'd0;
    endcase
  end

  // Window length clamped to its legal range.
  always_comb begin
    if (window_r < WIN_W'(2)) begin
      win = WIN_W'(2);
    end else if (window_r > WIN_W'(WINDOW_MAX)) begin
      win = WIN_W'(WINDOW_MAX);
    end else begin
      win = window_r;
    end
    cfg.enabled       = enabled_r;
    cfg.bucket_volume = bucket_r;
    cfg.win           = win;
    cfg.cap           = HEAD_W'(win - WIN_W'(1));
    cfg.threshold     = thresh_r;
    cfg.cooldown      = cool_r;
    cfg.clear         = clear_r;
  end

  vbtm_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .enabled (enabled_r),
    .push    (push),
    .full    (full),
    .in_data (in_data),
    .q_valid (q_valid),
    .q_head  (q_head),
    .q_pop   (q_pop)
  );

  vbtm_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .q_valid  (q_valid),
    .q_head   (q_head),
    .q_pop    (q_pop),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data)
  );

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
  import vbtm_pkg::*;

  localparam int STALL_LIMIT = 20000;
  localparam int SETTLE_CYCLES = 100;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic push = 1'b0;
  logic full;
  in_item_t in_data = '0;
  logic empty;
  logic pop = 1'b0;
  out_item_t out_data;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  volume_bucket_toxicity_monitor_top dut (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full), .in_data(in_data),
    .empty(empty), .pop(pop), .out_data(out_data), .psel(psel),
    .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  always #10 clk = ~clk;

  // Configuration shadow used by the predictor.
  logic        mon_enabled;
  logic [31:0] mon_bucket;
  logic [6:0]  mon_window;
  logic [16:0] mon_threshold;
  logic [31:0] mon_cooldown;

  // Per-instrument predictor state.
  logic [31:0] last_price [INSTRUMENTS];
  logic        price_valid [INSTRUMENTS];
  logic        last_side_buy [INSTRUMENTS];
  logic [32:0] buy_volume [INSTRUMENTS];
  logic [32:0] total_volume [INSTRUMENTS];
  logic [16:0] last_fraction [INSTRUMENTS];
  int unsigned fractions_held [INSTRUMENTS];
  logic [16:0] diff_ring [INSTRUMENTS][WINDOW_MAX];
  int unsigned diff_head [INSTRUMENTS];
  logic [31:0] diff_sum [INSTRUMENTS];
  logic [31:0] alert_time [INSTRUMENTS];
  logic        alert_raised [INSTRUMENTS];

  in_item_t  trade_queue[$];
  out_item_t expected_results[$];
  int errors = 0;
  int stall_cycles = 0;
  bit stimulus_done = 1'b0;
  int push_gap = 0;
  int pop_gap = 0;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Clear bucket sums, fractions and difference history of every instrument.
  function automatic void clear_windows();
    for (int i = 0; i < INSTRUMENTS; i++) begin
      buy_volume[i] = '0;
      total_volume[i] = '0;
      last_fraction[i] = '0;
      fractions_held[i] = 0;
      diff_head[i] = 0;
      diff_sum[i] = '0;
      for (int j = 0; j < WINDOW_MAX; j++) diff_ring[i][j] = '0;
    end
  endfunction

  function automatic void reset_model();
    mon_enabled = 1'b0;
    mon_bucket = 32'd10000;
    mon_window = 7'd50;
    mon_threshold = 17'd52429;
    mon_cooldown = 32'd300;
    for (int i = 0; i < INSTRUMENTS; i++) begin
      last_price[i] = '0;
      price_valid[i] = 1'b0;
      last_side_buy[i] = 1'b1;
      alert_time[i] = '0;
      alert_raised[i] = 1'b0;
    end
    clear_windows();
  endfunction

  // Predict the result of one trade and advance the state.
  function automatic void predict_trade(in_item_t t);
    out_item_t r;
    int unsigned inst, win, cap, h;
    logic buy;
    logic [16:0] frac, d;
    logic [48:0] scaled;
    logic [31:0] avg;
    bit passed;
    if (!mon_enabled) return;
    r = '0;
    r.instrument_out = t.instrument;
    inst = t.instrument;
    if (t.volume == 0) begin
      expected_results = {expected_results, r};
      return;
    end
    if (price_valid[inst] && t.price > last_price[inst]) buy = 1'b1;
    else if (price_valid[inst] && t.price < last_price[inst]) buy = 1'b0;
    else buy = last_side_buy[inst];
    last_price[inst] = t.price;
    price_valid[inst] = 1'b1;
    last_side_buy[inst] = buy;
    if (buy) buy_volume[inst] += {1'b0, t.volume};
    total_volume[inst] += {1'b0, t.volume};
    r.accepted = 1'b1;
    r.side_buy = buy;
    if (total_volume[inst] >= {1'b0, mon_bucket}) begin
      win = mon_window;
      if (win < 2) win = 2;
      if (win > WINDOW_MAX) win = WINDOW_MAX;
      cap = win - 1;
      scaled = {buy_volume[inst], 16'd0};
      frac = 17'(scaled / {16'd0, total_volume[inst]});
      r.bucket_closed = 1'b1;
      buy_volume[inst] = '0;
      total_volume[inst] = '0;
      if (fractions_held[inst] == 0) begin
        fractions_held[inst] = 1;
      end else begin
        d = (frac > last_fraction[inst]) ? frac - last_fraction[inst]
                                         : last_fraction[inst] - frac;
        h = diff_head[inst] % cap;
        if (fractions_held[inst] >= win) diff_sum[inst] -= diff_ring[inst][h];
        else fractions_held[inst]++;
        diff_ring[inst][h] = d;
        diff_sum[inst] += d;
        diff_head[inst] = (h + 1) % cap;
      end
      last_fraction[inst] = frac;
      if (fractions_held[inst] >= win) begin
        r.metric_valid = 1'b1;
        avg = diff_sum[inst] / cap;
        r.metric = avg[16:0];
        if (avg >= mon_threshold) begin
          passed = !alert_raised[inst] || (t.now_seconds >= alert_time[inst] &&
                   t.now_seconds - alert_time[inst] >= mon_cooldown);
          if (passed) begin
            r.alert = 1'b1;
            alert_raised[inst] = 1'b1;
            alert_time[inst] = t.now_seconds;
          end
        end
      end
    end
    expected_results = {expected_results, r};
  endfunction

  // Input driver: offers the queued trades with random gaps.
  always @(posedge clk) begin
    if (rst_n) begin
      if (push && !full) begin
        predict_trade(in_data);
        trade_queue.delete(0);
        push_gap <= pick_gap();
      end
      if (push && full) begin
        // Hold the beat until it is taken.
      end else if (push_gap > 0 && !(push && !full)) begin
        push <= 1'b0;
        push_gap <= push_gap - 1;
      end else if ((push && !full ? trade_queue.size() > 0 && pick_gap() == 0
                                  : trade_queue.size() > 0)) begin
        push <= 1'b1;
        in_data <= trade_queue[0];
      end else begin
        push <= 1'b0;
      end
    end
  end

  // Result monitor: pops with random stalls and checks each beat.
  always @(posedge clk) begin
    out_item_t e;
    if (rst_n) begin
      if (pop && !empty) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result beat for instrument %0d", out_data.instrument_out);
          errors++;
        end else begin
          e = expected_results[0];
          expected_results.delete(0);
          if (out_data.instrument_out !== e.instrument_out) begin
            $error("instrument_out expected %0d got %0d", e.instrument_out,
                   out_data.instrument_out);
            errors++;
          end
          if (out_data.accepted !== e.accepted) begin
            $error("accepted expected %0d got %0d", e.accepted, out_data.accepted);
            errors++;
          end
          if (out_data.side_buy !== e.side_buy) begin
            $error("side_buy expected %0d got %0d", e.side_buy, out_data.side_buy);
            errors++;
          end
          if (out_data.bucket_closed !== e.bucket_closed) begin
            $error("bucket_closed expected %0d got %0d", e.bucket_closed,
                   out_data.bucket_closed);
            errors++;
          end
          if (out_data.metric_valid !== e.metric_valid) begin
            $error("metric_valid expected %0d got %0d", e.metric_valid,
                   out_data.metric_valid);
            errors++;
          end
          if (out_data.metric !== e.metric) begin
            $error("metric expected %0d got %0d", e.metric, out_data.metric);
            errors++;
          end
          if (out_data.alert !== e.alert) begin
            $error("alert expected %0d got %0d", e.alert, out_data.alert);
            errors++;
          end
        end
      end
      if (pop_gap > 0) begin
        pop <= 1'b0;
        pop_gap <= pop_gap - 1;
      end else begin
        pop <= 1'b1;
        pop_gap <= pick_gap();
      end
    end
  end

  // Watchdog: cycles in which no beat moves on any channel.
  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty) || psel) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  // Register write: setup beat, then access beat.
  task automatic write_reg(reg_idx_t idx, logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= PADDR_W'(idx) << 2;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_ENABLED: mon_enabled = value[0];
      REG_BUCKET: begin
        mon_bucket = value;
        clear_windows();
      end
      REG_WINDOW: begin
        mon_window = value[6:0];
        clear_windows();
      end
      REG_THRESHOLD: mon_threshold = value[16:0];
      default: mon_cooldown = value;
    endcase
  endtask

  // Wait until all queued trades are taken and all results have come back.
  task automatic drain();
    while (trade_queue.size() > 0 || push || expected_results.size() > 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic in_item_t make_trade(int unsigned inst, logic [31:0] price,
                                          logic [31:0] vol, logic [31:0] now);
    in_item_t t;
    t.instrument = inst[3:0];
    t.price = price;
    t.volume = vol;
    t.now_seconds = now;
    return t;
  endfunction

  // Append one trade to the pending list of the driver.
  function automatic void add_trade(in_item_t t);
    trade_queue = {trade_queue, t};
  endfunction

  // Random phase: mostly walking prices with bucket-sized volumes.
  task automatic random_phase(int count, logic [31:0] bucket);
    logic [31:0] price [INSTRUMENTS];
    logic [31:0] now;
    int unsigned inst, r;
    logic [31:0] vol;
    now = $urandom_range(0, 1000);
    for (int i = 0; i < INSTRUMENTS; i++) price[i] = $urandom_range(1000, 2000);
    for (int n = 0; n < count; n++) begin
      inst = $urandom_range(0, 3) == 0 ? $urandom_range(0, 15) : $urandom_range(0, 2);
      r = $urandom_range(0, 99);
      if (r < 40) price[inst] = price[inst] + $urandom_range(1, 5);
      else if (r < 80) price[inst] = price[inst] - $urandom_range(1, 5);
      else if (r < 95) price[inst] = price[inst];
      else price[inst] = $urandom();
      r = $urandom_range(0, 99);
      if (r < 5) vol = 0;
      else if (r < 10) vol = $urandom();
      else vol = $urandom_range(1, bucket < 2 ? 2 : bucket);
      now = now + $urandom_range(0, 200);
      if ($urandom_range(0, 49) == 0) now = $urandom();
      add_trade(make_trade(inst, price[inst], vol, now));
    end
    drain();
  endtask

  initial begin
    reset_model();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Disabled trades are ignored.
    add_trade(make_trade(1, 100, 50, 0));
    drain();

    // Directed: extremes, tick rule, zero volume, zero bucket.
    write_reg(REG_ENABLED, 32'd1);
    write_reg(REG_BUCKET, 32'd0);
    write_reg(REG_WINDOW, 32'd0);
    write_reg(REG_THRESHOLD, 32'd0);
    write_reg(REG_COOLDOWN, 32'd0);
    add_trade(make_trade(0, 32'd0, 32'd0, 32'd0));
    add_trade(make_trade(0, 32'd5, 32'd1, 32'd0));
    add_trade(make_trade(0, 32'd5, 32'hFFFF_FFFF, 32'd1));
    add_trade(make_trade(0, 32'd4, 32'd1, 32'd1));
    add_trade(make_trade(0, 32'hFFFF_FFFF, 32'd7, 32'hFFFF_FFFF));
    add_trade(make_trade(15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd10));
    add_trade(make_trade(15, 32'd0, 32'hFFFF_FFFF, 32'd5));
    add_trade(make_trade(15, 32'd0, 32'd3, 32'd4));
    drain();

    // Cooldown with steadily advancing time.
    write_reg(REG_WINDOW, 32'd127);
    write_reg(REG_BUCKET, 32'd2);
    write_reg(REG_THRESHOLD, 32'd1);
    write_reg(REG_COOLDOWN, 32'd100);
    for (int i = 0; i < 12; i++)
      add_trade(make_trade(2, (i % 2) ? 32'd10 : 32'd20, 32'd2, 32'd50 * i));
    drain();

    // Random phases through several settings.
    write_reg(REG_WINDOW, 32'd2);
    write_reg(REG_BUCKET, 32'd1);
    write_reg(REG_THRESHOLD, 32'd65536);
    write_reg(REG_COOLDOWN, 32'hFFFF_FFFF);
    random_phase(250, 32'd1);
    write_reg(REG_BUCKET, 32'd300);
    write_reg(REG_WINDOW, 32'd5);
    write_reg(REG_THRESHOLD, 32'd8000);
    write_reg(REG_COOLDOWN, 32'd150);
    random_phase(400, 32'd300);
    write_reg(REG_BUCKET, 32'd200);
    write_reg(REG_WINDOW, 32'd64);
    write_reg(REG_THRESHOLD, 32'd3000);
    write_reg(REG_COOLDOWN, 32'd0);
    random_phase(400, 32'd200);
    write_reg(REG_BUCKET, 32'hFFFF_FFFF);
    write_reg(REG_WINDOW, 32'd3);
    random_phase(150, 32'hFFFF_FFFF);
    write_reg(REG_ENABLED, 32'd0);
    random_phase(20, 32'd100);
    drain();

    if (errors == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
